// File: src/ple_pkg.sv
package ple_pkg;

  // List depth and the fixed field widths.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEVELS   = (IDX_W < 1) ? 1 : IDX_W;
  localparam int NODES    = 1 << LEVELS;
  localparam int LVL_W    = $clog2(LEVELS) + 1;
  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic signed [VAL_W-1:0] EMPTY_LARGEST = -32'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply;   // update the cell row with the accepted item
    logic load;    // load the reduction tree and the order check
    logic reduce;  // halve the reduction tree once
    logic finish;  // last halving: load the result registers
  } ple_cmd_t;

endpackage

// File: src/ple_ctrl.sv
module ple_ctrl
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output ple_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_REDUCE
  } state_t;

  state_t             state_r;
  logic               busy_r;
  logic               out_valid_r;
  logic [LVL_W-1:0]   lvl_r;

  always_comb begin
    cmd.apply  = start && (state_r == S_IDLE);
    cmd.load   = (state_r == S_LOAD);
    cmd.reduce = (state_r == S_REDUCE);
    cmd.finish = (state_r == S_REDUCE) && (lvl_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_LOAD;
            busy_r  <= 1'b1;
          end
        end
        S_LOAD: begin
          state_r <= S_REDUCE;
          lvl_r   <= LVL_W'(LEVELS - 1);
        end
        S_REDUCE: begin
          if (lvl_r == '0) begin
            state_r     <= S_IDLE;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end else begin
            lvl_r <= lvl_r - 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// File: src/ple_dp.sv
module ple_dp
  import ple_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ple_cmd_t                 cmd,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic [STAT_W-1:0]        out_status,
  output logic [CNT_W-1:0]         out_count,
  output logic signed [VAL_W-1:0]  out_largest,
  output logic                     out_is_empty,
  output logic                     out_ascending
);

  logic signed [VAL_W-1:0] cells_r   [CAPACITY];
  logic signed [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]        length_r;
  logic [CNT_W-1:0]        length_nxt;
  logic [STAT_W-1:0]       status_r;
  logic [STAT_W-1:0]       status_nxt;
  logic                    asc_r;
  logic                    asc_nxt;
  logic signed [VAL_W-1:0] node_val_r [NODES];
  logic                    node_vld_r [NODES];

  logic [STAT_W-1:0]       res_status_r;
  logic [CNT_W-1:0]        res_count_r;
  logic signed [VAL_W-1:0] res_largest_r;
  logic                    res_empty_r;
  logic                    res_asc_r;

  logic [POS_W-1:0] len_ext;
  logic             list_full;

  assign len_ext   = POS_W'(length_r);
  assign list_full = int'(length_r) >= CAPACITY;

  // Every cell picks its own neighbor, so an insert or erase shifts the whole row at once.
  always_comb begin
    cells_nxt  = cells_r;
    length_nxt = length_r;
    status_nxt = ST_DONE;
    case (in_command)
      CMD_INSERT: begin
        if (in_position > len_ext) begin
          status_nxt = ST_BAD_POS;
        end else if (list_full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (POS_W'(i) == in_position) begin
              cells_nxt[i] = in_value;
            end else if (i > 0 && POS_W'(i) > in_position) begin
              cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
            end
          end
          length_nxt = length_r + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (in_position >= len_ext) begin
          status_nxt = ST_BAD_POS;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (POS_W'(i) >= in_position) begin
              cells_nxt[i] = cells_r[i + 1];
            end
          end
          length_nxt = length_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Adjacent pairs are checked side by side.
  always_comb begin
    asc_nxt = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      if (int'(length_r) > i && cells_r[i-1] > cells_r[i]) begin
        asc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
    end else if (cmd.apply) begin
      length_r <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      cells_r  <= cells_nxt;
      status_r <= status_nxt;
    end
    if (cmd.load) begin
      asc_r <= asc_nxt;
      for (int i = 0; i < NODES; i++) begin
        node_val_r[i] <= cells_r[(i < CAPACITY) ? i : 0];
        node_vld_r[i] <= (i < CAPACITY) && (int'(length_r) > i);
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < NODES / 2; i++) begin
        node_vld_r[i] <= node_vld_r[2*i] || node_vld_r[2*i+1];
        if (!node_vld_r[2*i]) begin
          node_val_r[i] <= node_val_r[2*i+1];
        end else if (!node_vld_r[2*i+1]) begin
          node_val_r[i] <= node_val_r[2*i];
        end else if (node_val_r[2*i+1] > node_val_r[2*i]) begin
          node_val_r[i] <= node_val_r[2*i+1];
        end else begin
          node_val_r[i] <= node_val_r[2*i];
        end
      end
    end
  end

  // The last halving folds the root pair straight into the result.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= status_r;
      res_count_r  <= length_r;
      res_empty_r  <= (length_r == '0);
      res_asc_r    <= asc_r;
      if (!node_vld_r[0] && !node_vld_r[1]) begin
        res_largest_r <= EMPTY_LARGEST;
      end else if (!node_vld_r[0]) begin
        res_largest_r <= node_val_r[1];
      end else if (!node_vld_r[1]) begin
        res_largest_r <= node_val_r[0];
      end else if (node_val_r[1] > node_val_r[0]) begin
        res_largest_r <= node_val_r[1];
      end else begin
        res_largest_r <= node_val_r[0];
      end
    end
  end

  assign out_status    = res_status_r;
  assign out_count     = res_count_r;
  assign out_largest   = res_largest_r;
  assign out_is_empty  = res_empty_r;
  assign out_ascending = res_asc_r;

endmodule

// File: src/positional_list_engine.sv
// Channel   Ports                                        Handshake
// input     in_command, in_value, in_position            start high while busy low
// result    out_status, out_count, out_largest,          out_valid high for one cycle
//           out_is_empty, out_ascending
//
// An item is taken at the edge where start is high and busy is low. That edge
// also updates the shifting cell row for an insert or erase.
// The largest element comes from a registered max tree that is loaded in the
// next cycle and halved once per cycle, $clog2(CAPACITY) halvings in all.
// The result is strobed as the last halving loads the result registers, and
// busy drops in that same cycle, so a new item is taken only once the last
// result is out. Reset is synchronous and active low and empties the list.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [CNT_W-1:0]         out_count,
  output logic signed [VAL_W-1:0]  out_largest,
  output logic                     out_is_empty,
  output logic                     out_ascending
);

  // Command bundle from the sequencer to the list datapath.
  ple_cmd_t cmd;

  // The controller walks each item through update, tree load and the halvings.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the cell row, the length, the max tree and the results.
  ple_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_largest   (out_largest),
    .out_is_empty  (out_is_empty),
    .out_ascending (out_ascending)
  );

  // An accepted item keeps the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a busy period and frees the block at once.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a preceding busy period");

  // An empty list reports the empty maximum and counts as ordered.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_largest == EMPTY_LARGEST && out_ascending
                                     && out_count == '0))
    else $error("empty list result is inconsistent");

  // The count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_count) <= CAPACITY))
    else $error("result count beyond the list depth");

endmodule

// File: tb/sv/positional_list_engine_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the positional list engine. A shadow list, kept as
// a queue of signed words, is updated at every edge that takes an item, and
// the result that the item must produce is queued at the same moment. An
// always block compares each strobed result, field by field, with the oldest
// queued result. Named tests run in turn from one initial block: the empty
// list, the value extremes, a full list, and a long random run.
module positional_list_engine_tb;
  import ple_pkg::*;

  // Command code 3 has no operation of its own and acts as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1300;

  // The values of one result item, as the list should report them.
  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
    logic signed [VAL_W-1:0]  largest;
    logic                     is_empty;
    logic                     ascending;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic signed [VAL_W-1:0]  in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [CNT_W-1:0]         out_count;
  logic signed [VAL_W-1:0]  out_largest;
  logic                     out_is_empty;
  logic                     out_ascending;

  // Shadow copy of the list contents, front of the list at index 0.
  logic signed [VAL_W-1:0]  list_shadow[$];
  // Results that the block still owes, oldest first.
  list_result_t             owed_results[$];

  int errors;
  int items_taken;
  int results_seen;
  int full_rejects;
  int position_rejects;
  int full_list_results;
  // While set, the sender raises start again right after each item is taken.
  bit back_to_back;

  positional_list_engine uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_largest   (out_largest),
    .out_is_empty  (out_is_empty),
    .out_ascending (out_ascending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one taken item to the shadow list and returns the result that the
  // block must strobe for it. An illegal position is checked before a full
  // list, so an insert past the end of a full list reports a bad position.
  function automatic list_result_t update_shadow_list(input logic [CMD_W-1:0] cmd,
                                                      input logic signed [VAL_W-1:0] val,
                                                      input logic [POS_W-1:0] pos);
    list_result_t res;
    int n;
    n = list_shadow.size();
    res.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (int'(pos) > n) begin
        res.status = ST_BAD_POS;
      end else if (n >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        list_shadow.insert(int'(pos), val);
      end
    end else if (cmd == CMD_ERASE) begin
      if (int'(pos) >= n) begin
        res.status = ST_BAD_POS;
      end else begin
        list_shadow.delete(int'(pos));
      end
    end
    n = list_shadow.size();
    res.count = CNT_W'(n);
    res.is_empty = (n == 0);
    res.ascending = 1'b1;
    res.largest = EMPTY_LARGEST;
    if (n > 0) begin
      res.largest = list_shadow[0];
      for (int i = 1; i < n; i++) begin
        if (list_shadow[i] > res.largest) res.largest = list_shadow[i];
        if (list_shadow[i-1] > list_shadow[i]) res.ascending = 1'b0;
      end
    end
    return res;
  endfunction

  // Presents one item and holds it until an edge with busy low takes it.
  // Signals are read right after the edge, so busy is its value before the
  // edge, the same value the block used to decide whether to take the item.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    list_result_t res;
    int gap;
    start       <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (busy);
    res = update_shadow_list(cmd, val, pos);
    owed_results.push_back(res);
    items_taken++;
    if (res.status == ST_FULL) full_rejects++;
    if (res.status == ST_BAD_POS) position_rejects++;
    if (res.count == CNT_W'(CAPACITY)) full_list_results++;
    // A gap of zero leaves start high so that the next item follows at once.
    gap = back_to_back ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result checker. The block cannot be held off, so every strobe is taken.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result strobed with no item outstanding");
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          errors++;
        end
        if (out_largest !== want.largest) begin
          $error("largest: expected %0d, got %0d", want.largest, out_largest);
          errors++;
        end
        if (out_is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, out_is_empty);
          errors++;
        end
        if (out_ascending !== want.ascending) begin
          $error("ascending: expected %0b, got %0b", want.ascending, out_ascending);
          errors++;
        end
      end
    end
  end

  // Values lean toward the extremes and toward a narrow band around zero, so
  // that equal neighbors and sign changes are common.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel == 5) return 32'sh7FFF_FFFF;
    if (sel == 6) return 32'sh8000_0000;
    if (sel == 7) return (($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1);
    return $signed($urandom_range(0, 15)) - 32'sd8;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int insert_pct, input int erase_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return CMD_INSERT;
    if (r < insert_pct + erase_pct) return CMD_ERASE;
    return ($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_SPARE;
  endfunction

  // Most positions are legal for the current list; the rest span the whole
  // field, which mostly lands beyond the end.
  function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
    int n;
    n = list_shadow.size();
    if ($urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 255));
    if (cmd == CMD_INSERT) return POS_W'($urandom_range(0, n));
    if (cmd == CMD_ERASE) return (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Every command on an empty list, with positions at both ends of the field.
  task automatic test_empty_list();
    send_item(CMD_QUERY, 32'sd5, 8'd0);
    send_item(CMD_SPARE, -32'sd7, 8'd3);
    send_item(CMD_ERASE, 32'sd0, 8'd0);
    send_item(CMD_ERASE, 32'sd0, 8'd255);
    send_item(CMD_INSERT, 32'sd9, 8'd1);
    send_item(CMD_INSERT, 32'sd9, 8'd255);
  endtask

  // The most positive and most negative values, inserts at the front, middle
  // and end, erases at each end, and a drain back to an empty list.
  task automatic test_value_extremes();
    send_item(CMD_INSERT, 32'sh7FFF_FFFF, 8'd0);
    send_item(CMD_INSERT, 32'sh8000_0000, 8'd0);
    send_item(CMD_INSERT, -32'sd1, 8'd2);
    send_item(CMD_INSERT, 32'sd0, 8'd1);
    send_item(CMD_ERASE, 32'sd0, 8'd4);
    send_item(CMD_ERASE, 32'sd0, 8'd3);
    send_item(CMD_ERASE, 32'sd0, 8'd1);
    send_item(CMD_ERASE, 32'sd0, 8'd0);
    send_item(CMD_ERASE, 32'sd0, 8'd0);
  endtask

  // Fills the list in order, then probes it: a legal insert is refused as
  // full, an insert past the end as a bad position, and erasing the last
  // element frees room again.
  task automatic test_full_list();
    while (list_shadow.size() < CAPACITY) begin
      send_item(CMD_INSERT, $signed(32'(list_shadow.size() * 3)) - 32'sd20,
                POS_W'(list_shadow.size()));
    end
    send_item(CMD_INSERT, 32'sd1, 8'd0);
    send_item(CMD_INSERT, 32'sd1, POS_W'(CAPACITY));
    send_item(CMD_INSERT, 32'sd1, POS_W'(CAPACITY + 1));
    send_item(CMD_ERASE, 32'sd0, POS_W'(CAPACITY - 1));
  endtask

  // Random traffic in phases: some fill the list, some drain it, some keep it
  // sorted so the order flag stays set across long lists, and some are mixed.
  // About a third of the phases run with no gaps between items.
  task automatic test_random_traffic(input int total);
    int sent;
    int phase_len;
    int kind;
    int at;
    logic [CMD_W-1:0] cmd;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(10, 60);
      kind = $urandom_range(0, 3);
      back_to_back = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < phase_len && sent < total; k++) begin
        case (kind)
          0: cmd = pick_command(70, 15);
          1: cmd = pick_command(15, 70);
          2: cmd = pick_command(55, 35);
          default: cmd = pick_command(40, 40);
        endcase
        val = pick_value();
        pos = pick_position(cmd);
        // In a sorted phase most inserts go after every element not greater
        // than the new value, which keeps the list in order.
        if (kind == 2 && cmd == CMD_INSERT && $urandom_range(0, 9) != 0) begin
          val = $signed($urandom_range(0, 40)) - 32'sd20;
          at = 0;
          foreach (list_shadow[i]) if (list_shadow[i] <= val) at = i + 1;
          pos = POS_W'(at);
        end
        send_item(cmd, val, pos);
        sent++;
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    int waited;
    errors = 0;
    items_taken = 0;
    results_seen = 0;
    full_rejects = 0;
    position_rejects = 0;
    full_list_results = 0;
    back_to_back = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_QUERY;
    in_value    = '0;
    in_position = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_value_extremes();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);

    // Let every owed result arrive, then watch a little longer for strays.
    start <= 1'b0;
    waited = 0;
    while (owed_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      errors++;
    end
    repeat (12) @(posedge clk);

    $display("Covered %0d items and %0d results: %0d refused as full, %0d bad positions,",
             items_taken, results_seen, full_rejects, position_rejects);
    $display("and %0d results with the list at its full depth of %0d.",
             full_list_results, CAPACITY);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run takes well under a tenth
  // of this.
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
